>>> rtl/swk_pkg.sv
// Shared constants, types and tables for the swerve wheel kinematics unit.
`timescale 1ns / 1ps

package swk_pkg;

    localparam int WHEELS          = 4;
    localparam int WHEEL_W         = $clog2(WHEELS);
    localparam int CORDIC_STEPS    = 16;
    localparam int TAB_LEN         = 24;
    localparam int NSTEPS          = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    localparam int STEP_W          = $clog2(NSTEPS);
    localparam int ANGLE_FRAC_BITS = 6;

    localparam int XW = 28;
    localparam int AW = 34;

    localparam int DEG_W = 8 + ANGLE_FRAC_BITS;
    localparam int PW    = AW + DEG_W + 1;
    localparam logic signed [DEG_W:0] DEG_SCALE = (DEG_W + 1)'(180 << ANGLE_FRAC_BITS);

    localparam int P90_RAW = 90 << ANGLE_FRAC_BITS;
    localparam int P90     = (P90_RAW > 32767) ? 32767 : P90_RAW;
    localparam int M90     = (-P90_RAW < -32768) ? -32768 : -P90_RAW;

    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    localparam logic signed [AW-1:0] PI_BA      = {{(AW-32){1'b0}}, 32'h8000_0000};
    localparam logic signed [AW-1:0] TWO_PI_BA  = PI_BA <<< 1;
    localparam logic signed [AW-1:0] HALF_PI_BA = PI_BA >>> 1;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATE_THR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_THR   = 1'b1;

    localparam int MEM_W = 32;

    typedef enum logic [1:0] {
        SPIN_NONE,
        SPIN_RIGHT,
        SPIN_LEFT
    } spin_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VEC_RUN,
        ST_VEC_GAIN,
        ST_WHEEL,
        ST_ROT_START,
        ST_ROT_RUN,
        ST_VEC2_START,
        ST_VEC2_RUN,
        ST_VEC2_GAIN,
        ST_DEG,
        ST_ROUND,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic vmode;
    } cordic_ctl_t;

    function automatic logic signed [AW-1:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return $signed({{(AW-32){1'b0}}, v});
    endfunction

    function automatic logic signed [13:0] zd_code(input logic [WHEEL_W-1:0] w,
                                                   input spin_t s);
        logic signed [13:0] r;
        r = '0;
        unique case (s)
            SPIN_RIGHT:
            begin
                case (w)
                    2'd0:    r = 14'sd1024;
                    2'd1:    r = 14'sd3072;
                    2'd2:    r = -14'sd1024;
                    default: r = -14'sd3072;
                endcase
            end
            SPIN_LEFT:
            begin
                case (w)
                    2'd0:    r = -14'sd3072;
                    2'd1:    r = -14'sd1024;
                    2'd2:    r = 14'sd3072;
                    default: r = 14'sd1024;
                endcase
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] park_angle(input logic [WHEEL_W-1:0] w);
        logic signed [15:0] r;
        case (w)
            2'd1:    r = 16'(P90);
            2'd2:    r = 16'(M90);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/swk_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module swk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/swk_cordic.sv
// Shared iterative CORDIC, vectoring or rotation mode, one step per cycle.
`timescale 1ns / 1ps

module swk_cordic
    import swk_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cordic_ctl_t          ctl,
    input  logic signed [XW-1:0] x0,
    input  logic signed [XW-1:0] y0,
    input  logic signed [AW-1:0] z0,
    output logic signed [XW-1:0] x,
    output logic signed [XW-1:0] y,
    output logic signed [AW-1:0] z,
    output logic                 busy
);

    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [AW-1:0] z_reg, z_next;
    logic [STEP_W-1:0]    iter_reg, iter_next;
    logic                 busy_reg, busy_next;
    logic                 vmode_reg;
    logic signed [XW-1:0] dx, dy;
    logic signed [AW-1:0] at;
    logic                 dir_pos, plus;

    always_comb
    begin
        dx      = y_reg >>> iter_reg;
        dy      = x_reg >>> iter_reg;
        at      = atan_entry(5'(iter_reg));
        dir_pos = vmode_reg ? !y_reg[XW-1] : !z_reg[AW-1];
        plus    = (vmode_reg == dir_pos);
        x_next  = x_reg;
        y_next  = y_reg;
        z_next  = z_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        if (ctl.start)
        begin
            x_next    = x0;
            y_next    = y0;
            z_next    = z0;
            iter_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = plus ? x_reg + dx : x_reg - dx;
            y_next = plus ? y_reg - dy : y_reg + dy;
            z_next = plus ? z_reg + at : z_reg - at;
            iter_next = iter_reg + 1'b1;
            if (iter_reg == STEP_W'(NSTEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        if (ctl.start)
        begin
            vmode_reg <= ctl.vmode;
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
    assign busy = busy_reg;

endmodule

>>> rtl/swerve_wheel_kinematics_unit.sv
// Top level: swerve drive inverse kinematics, four wheel results per command.
// Stop command: no CORDIC, each wheel result takes its park angle and zero speed. Moving
// command: translation CORDIC and gain, then per wheel two 16-step CORDIC passes (rotation,
// then vectoring) plus gain, scale, round, emit. One command at a time, one shared CORDIC;
// a new command is taken only in idle, after the last wheel result is emitted.
// Reset marks the wheel history and counts invalid, so they read as zero, and loads thresholds 20 and 19200.
`timescale 1ns / 1ps

module swerve_wheel_kinematics_unit
    import swk_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,   // x_speed, y_speed, z_speed
    input  logic                 s_axis_tuser,   // stop
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [55:0]          m_axis_tdata,   // wheel, steer_angle, drive_speed, turn_count
    output logic                 m_axis_tlast    // last
);

    state_t state_reg, state_next;

    logic [14:0] rot_thr_reg;
    logic [15:0] jump_thr_reg;

    logic signed [15:0]   zin_reg;
    logic                 stop_reg;
    logic                 base_reg;
    logic                 zero_reg;
    logic                 neg_reg;
    logic [16:0]          az_reg;
    logic signed [XW-1:0] smag_reg;
    logic signed [AW-1:0] adir_reg;
    logic signed [15:0]   e_reg;
    logic signed [XW-1:0] rx0_reg;
    logic signed [XW-1:0] m_reg;
    logic signed [AW-1:0] asum_reg;
    logic signed [PW-1:0] p_reg;
    logic [16:0]          spd_reg;
    logic signed [15:0]   ang_reg;
    logic [WHEEL_W-1:0]   wheel_reg;
    logic [WHEELS-1:0]    valid_reg;

    logic                 out_valid_reg;
    logic [WHEEL_W-1:0]   out_wheel_reg;
    logic [15:0]          out_ang_reg;
    logic [16:0]          out_spd_reg;
    logic [15:0]          out_cnt_reg;
    logic                 out_last_reg;

    cordic_ctl_t          cctl;
    logic signed [XW-1:0] cx0, cy0, cx, cy;
    logic signed [AW-1:0] cz0, cz;
    logic                 cbusy;

    logic                 in_fire, emit_go;

    logic signed [15:0]   xin, yin, zin;
    logic signed [XW-1:0] xs, ys;
    logic                 in_zero;

    logic signed [XW+30:0] vprod;
    logic signed [XW-1:0]  gain_x;
    logic signed [AW-1:0]  wrapped;

    spin_t                spin;
    logic signed [13:0]   zd;
    logic signed [AW:0]   ev;
    logic signed [15:0]   eq, eraw, efold;
    logic [54:0]          rprod;
    logic signed [AW-1:0] th, thf;
    logic                 thneg;

    logic signed [XW-1:0] cc, cs, vx, vxa, vya;
    logic                 vzero;

    logic [XW:0]          msum;
    logic [XW-8:0]        mshift;
    logic signed [PW-1:0] pabs;
    logic [PW-32:0]       qround;
    logic signed [15:0]   ang_round;

    logic [MEM_W-1:0]     rdata, wdata;
    logic signed [15:0]   prev_ang, cur_ang;
    logic [15:0]          cur_cnt, new_cnt;
    logic signed [17:0]   dang, jt;

    function automatic logic signed [AW-1:0] wrap_angle(input logic signed [AW-1:0] a,
                                                        input logic base);
        logic signed [AW-1:0] s;
        s = base ? a + PI_BA : a;
        if (s > PI_BA)
        begin
            s = s - TWO_PI_BA;
        end
        return s;
    endfunction

    swk_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cctl),
        .x0    (cx0),
        .y0    (cy0),
        .z0    (cz0),
        .x     (cx),
        .y     (cy),
        .z     (cz),
        .busy  (cbusy)
    );

    swk_ram #(
        .WIDTH (MEM_W),
        .DEPTH (WHEELS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (emit_go),
        .waddr (wheel_reg),
        .wdata (wdata),
        .raddr (wheel_reg),
        .rdata (rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = s_axis_tuser ? ST_WHEEL : ST_VEC_RUN;
                end
            end
            ST_VEC_RUN:    state_next = cbusy ? ST_VEC_RUN : ST_VEC_GAIN;
            ST_VEC_GAIN:   state_next = ST_WHEEL;
            ST_WHEEL:      state_next = stop_reg ? ST_EMIT : ST_ROT_START;
            ST_ROT_START:  state_next = ST_ROT_RUN;
            ST_ROT_RUN:    state_next = cbusy ? ST_ROT_RUN : ST_VEC2_START;
            ST_VEC2_START: state_next = ST_VEC2_RUN;
            ST_VEC2_RUN:   state_next = cbusy ? ST_VEC2_RUN : ST_VEC2_GAIN;
            ST_VEC2_GAIN:  state_next = ST_DEG;
            ST_DEG:        state_next = ST_ROUND;
            ST_ROUND:      state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = (wheel_reg == WHEEL_W'(WHEELS - 1)) ? ST_IDLE : ST_WHEEL;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        emit_go       = 1'b0;
        cctl          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cctl.start    = s_axis_tvalid && !s_axis_tuser;
                cctl.vmode    = 1'b1;
            end
            ST_ROT_START:
            begin
                cctl.start = 1'b1;
            end
            ST_VEC2_START:
            begin
                cctl.start = 1'b1;
                cctl.vmode = 1'b1;
            end
            ST_EMIT:
            begin
                emit_go = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                cctl = '0;
            end
        endcase
    end

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // datapath
    always_comb
    begin
        xin     = $signed(s_axis_tdata[15:0]);
        yin     = $signed(s_axis_tdata[31:16]);
        zin     = $signed(s_axis_tdata[47:32]);
        xs      = XW'($signed({xin, 8'b0}));
        ys      = XW'($signed({yin, 8'b0}));
        in_zero = (xin == '0) && (yin == '0);

        vprod   = cx * $signed({1'b0, GAIN_Q30});
        gain_x  = vprod[XW+29:30];
        wrapped = wrap_angle(cz, base_reg);

        if ($signed({zin_reg[15], zin_reg}) >= $signed({2'b0, rot_thr_reg}))
        begin
            spin = SPIN_RIGHT;
        end
        else if ($signed({zin_reg[15], zin_reg}) <= -$signed({2'b0, rot_thr_reg}))
        begin
            spin = SPIN_LEFT;
        end
        else
        begin
            spin = SPIN_NONE;
        end
        zd    = zd_code(wheel_reg, spin);
        ev    = ((AW+1)'(zd) <<< 19) - (AW+1)'(adir_reg);
        eq    = ev[34:19];
        eraw  = eq + ((ev[AW] && (ev[18:0] != '0)) ? 16'sd1 : 16'sd0);
        if (eraw > 16'sd4096)
        begin
            efold = eraw - 16'sd8192;
        end
        else if (eraw < -16'sd4096)
        begin
            efold = eraw + 16'sd8192;
        end
        else
        begin
            efold = eraw;
        end
        rprod = 55'({az_reg, 8'b0}) * 55'(GAIN_Q30);

        th    = AW'(e_reg) <<< 19;
        thneg = 1'b0;
        thf   = th;
        if (th > HALF_PI_BA)
        begin
            thf   = th - PI_BA;
            thneg = 1'b1;
        end
        else if (th < -HALF_PI_BA)
        begin
            thf   = th + PI_BA;
            thneg = 1'b1;
        end

        cc    = neg_reg ? -cx : cx;
        cs    = neg_reg ? -cy : cy;
        vx    = smag_reg + cc;
        vzero = (vx == '0) && (cs == '0);
        vxa   = vx[XW-1] ? -vx : vx;
        vya   = vx[XW-1] ? -cs : cs;

        msum   = {1'b0, m_reg} + (XW+1)'(128);
        mshift = msum[XW:8];
        pabs   = p_reg[PW-1] ? -p_reg : p_reg;
        qround = (PW-31)'((pabs + (PW'(1) <<< 30)) >>> 31);
        if (!p_reg[PW-1])
        begin
            ang_round = (qround > (PW-31)'(32767)) ? 16'sd32767 : 16'(qround);
        end
        else
        begin
            ang_round = (qround > (PW-31)'(32768)) ? -16'sd32768 : -16'(qround);
        end

        prev_ang = valid_reg[wheel_reg] ? $signed(rdata[15:0]) : 16'sd0;
        cur_cnt  = valid_reg[wheel_reg] ? rdata[31:16] : 16'd0;
        cur_ang  = stop_reg ? park_angle(wheel_reg) : ang_reg;
        dang     = 18'(cur_ang) - 18'(prev_ang);
        jt       = $signed({2'b0, jump_thr_reg});
        new_cnt  = cur_cnt;
        if (!stop_reg)
        begin
            if (dang >= jt)
            begin
                new_cnt = cur_cnt + 16'd1;
            end
            else if (dang <= -jt)
            begin
                new_cnt = cur_cnt - 16'd1;
            end
        end
        wdata = {new_cnt, cur_ang};

        cx0 = '0;
        cy0 = '0;
        cz0 = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cx0 = xs[XW-1] ? -xs : xs;
                cy0 = xs[XW-1] ? -ys : ys;
            end
            ST_ROT_START:
            begin
                cx0 = rx0_reg;
                cz0 = thf;
            end
            ST_VEC2_START:
            begin
                cx0 = vxa;
                cy0 = vya;
            end
            default:
            begin
                cx0 = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    zin_reg  <= zin;
                    stop_reg <= s_axis_tuser;
                    az_reg   <= zin[15] ? -17'(zin) : 17'(zin);
                    base_reg <= xs[XW-1];
                    zero_reg <= in_zero;
                end
            end
            ST_VEC_GAIN:
            begin
                smag_reg <= zero_reg ? '0 : gain_x;
                adir_reg <= zero_reg ? '0 : wrapped;
            end
            ST_WHEEL:
            begin
                e_reg   <= efold;
                rx0_reg <= $signed(XW'(rprod[54:30]));
            end
            ST_ROT_START:
            begin
                neg_reg <= thneg;
            end
            ST_VEC2_START:
            begin
                zero_reg <= vzero;
                base_reg <= vx[XW-1];
            end
            ST_VEC2_GAIN:
            begin
                m_reg    <= zero_reg ? '0 : gain_x;
                asum_reg <= adir_reg + (zero_reg ? '0 : wrapped);
            end
            ST_DEG:
            begin
                p_reg   <= asum_reg * DEG_SCALE;
                spd_reg <= (mshift > (XW-7)'(131071)) ? 17'h1FFFF : mshift[16:0];
            end
            ST_ROUND:
            begin
                ang_reg <= ang_round;
            end
            default:
            begin
                ang_reg <= ang_reg;
            end
        endcase
        if (emit_go)
        begin
            out_wheel_reg <= wheel_reg;
            out_ang_reg   <= cur_ang;
            out_spd_reg   <= stop_reg ? 17'd0 : spd_reg;
            out_cnt_reg   <= new_cnt;
            out_last_reg  <= (wheel_reg == WHEEL_W'(WHEELS - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rot_thr_reg   <= 15'd20;
            jump_thr_reg  <= 16'd19200;
            wheel_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ROTATE_THR: rot_thr_reg  <= cfg_data[14:0];
                    REG_JUMP_THR:   jump_thr_reg <= cfg_data;
                    default:        rot_thr_reg  <= rot_thr_reg;
                endcase
            end
            if (emit_go)
            begin
                wheel_reg            <= wheel_reg + 1'b1;
                valid_reg[wheel_reg] <= 1'b1;
                out_valid_reg        <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_cnt_reg, out_spd_reg, out_ang_reg, out_wheel_reg};
    assign m_axis_tlast  = out_last_reg;

    a_last_wheel: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[1:0] == WHEEL_W'(WHEELS - 1))))
        else $error("tlast does not match the last wheel");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cctl.start |-> !cbusy)
        else $error("CORDIC started while busy");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (wheel_reg == '0) && !cbusy)
        else $error("idle with work in flight");

    a_emit_advance: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go && (wheel_reg != WHEEL_W'(WHEELS - 1)) |=> (state_reg == ST_WHEEL))
        else $error("wheel sequence broken");

endmodule
